[rtl/hed_pkg.sv]
// Shared types, codes and name tables of the HTML entity decoder.
package hed_pkg;

  // Character codes that the decoder looks for.
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_QUEST = 8'h3F;

  // Numeric codes saturate at this value.
  localparam logic [16:0] CODE_LIMIT = 17'h10000;

  // Kinds of result bundle that a decode step can produce.
  localparam logic [2:0] BUN_NONE     = 3'd0;
  localparam logic [2:0] BUN_BYTE     = 3'd1;
  localparam logic [2:0] BUN_DONE     = 3'd2;
  localparam logic [2:0] BUN_AMP      = 3'd3;
  localparam logic [2:0] BUN_AMP_OVF  = 3'd4;
  localparam logic [2:0] BUN_AMP_HASH = 3'd5;
  localparam logic [2:0] BUN_CODE     = 3'd6;
  localparam logic [2:0] BUN_NAME     = 3'd7;

  // Known entity names, first character in the low byte.
  localparam int NUM_NAMES = 13;
  localparam logic [63:0] NAME_TXT [NUM_NAMES] = '{
    64'h746C, 64'h7467, 64'h706D61, 64'h746F7571, 64'h736F7061,
    64'h7073626E, 64'h79706F63, 64'h676572, 64'h6564617274,
    64'h6F727565, 64'h646E756F70, 64'h6E6579, 64'h746E6563
  };
  localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
    3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd4
  };
  // Replacement bytes, first byte in the low byte.
  localparam logic [23:0] NAME_OUT [NUM_NAMES] = '{
    24'h3C, 24'h3E, 24'h26, 24'h22, 24'h27, 24'h20, 24'hA9C2, 24'hAEC2,
    24'hA284E2, 24'hAC82E2, 24'hA3C2, 24'hA5C2, 24'hA2C2
  };
  // Index of the last replacement byte.
  localparam logic [1:0] NAME_LAST [NUM_NAMES] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       fetch;
    logic       hold;
    logic       name_init;
    logic       code_clear;
    logic       code_acc;
    logic       code_hex;
    logic [2:0] bun_sel;
    logic       emit;
    logic       rp_start;
    logic       rp_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sym_end;
    logic sym_term;
    logic sym_amp;
    logic sym_semi;
    logic sym_hash;
    logic sym_x;
    logic sym_brk;
    logic dig_dec;
    logic dig_hex;
    logic held_zero;
    logic held_full;
    logic rp_active;
    logic rp_last;
    logic bun_last;
    logic slot_free;
  } sts_t;

endpackage

[rtl/hed_in_if.sv]
// Request channel that carries raw text bytes into the decoder.
interface hed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

[rtl/hed_out_if.sv]
// Request channel that carries decoded results out of the decoder.
interface hed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       string_done;
  logic       entity_overflow;

  modport source (output valid, output out_byte, output has_byte, output string_done,
                  output entity_overflow, input ready);
  modport sink (input valid, input out_byte, input has_byte, input string_done,
                input entity_overflow, output ready);
endinterface

[rtl/hed_dp.sv]
// Datapath of the HTML entity decoder: held bytes, code, bundles and output register.
module hed_dp #(
  parameter int MAX_ENTITY = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data,
  input  logic [7:0]      in_byte,
  input  logic            end_of_text,
  input  hed_pkg::cmd_t   cmd,
  output hed_pkg::sts_t   sts,
  hed_out_if.source       text_out
);

  localparam int CW = $clog2(MAX_ENTITY + 1);
  localparam int AW = $clog2(MAX_ENTITY);

  logic [7:0]    terminator;
  logic [7:0]    item_byte;
  logic          item_end;
  logic [7:0]    held_mem [MAX_ENTITY];
  logic [7:0]    rd_data;
  logic [CW-1:0] held_count;
  logic [CW-1:0] rp_idx;
  logic [CW-1:0] rp_len;
  logic          rp_active;
  logic [12:0]   mask;
  logic [12:0]   mask_next;
  logic [16:0]   code;
  logic [7:0]    bun_b0;
  logic [7:0]    bun_b1;
  logic [7:0]    bun_b2;
  logic [1:0]    bun_lastidx;
  logic          bun_has;
  logic          bun_done;
  logic          bun_ovf;
  logic [1:0]    eidx;
  logic          out_valid;

  logic [7:0]    sym_byte;
  logic          sym_end;
  logic [3:0]    dval;
  logic          dig_dec;
  logic          dig_hex;
  logic [21:0]   acc;
  logic [23:0]   name_bytes;
  logic [1:0]    name_last;
  logic [23:0]   code_bytes;
  logic [1:0]    code_last;
  logic [7:0]    emit_byte;

  // Terminator register.
  always_ff @(posedge clk) begin
    if (rst) begin
      terminator <= 8'd60;
    end else if (cfg_we) begin
      terminator <= cfg_data;
    end
  end

  // Current item.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_byte <= in_byte;
      item_end  <= end_of_text;
    end
  end

  // Held name bytes; written while a name builds, read during replay.
  always_ff @(posedge clk) begin
    if (cmd.hold) begin
      held_mem[held_count[AW-1:0]] <= sym_byte;
    end
    if (cmd.fetch) begin
      rd_data <= held_mem[rp_idx[AW-1:0]];
    end
  end

  // Symbol under decode: a replayed held byte or the item itself.
  assign sym_byte = rp_active ? rd_data : item_byte;
  assign sym_end  = rp_active ? 1'b0 : item_end;

  // Digit decode for both bases.
  always_comb begin
    dval    = 4'd0;
    dig_dec = 1'b0;
    dig_hex = 1'b0;
    if (!sym_end) begin
      if (sym_byte inside {[8'h30:8'h39]}) begin
        dval    = sym_byte[3:0];
        dig_dec = 1'b1;
        dig_hex = 1'b1;
      end else if (sym_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
        dval    = sym_byte[3:0] + 4'd9;
        dig_hex = 1'b1;
      end
    end
  end

  // One digit step of the numeric code, saturated.
  assign acc = (cmd.code_hex ? {1'b0, code, 4'b0000}
                             : ({2'b00, code, 3'b000} + {4'b0000, code, 1'b0}))
               + {18'd0, dval};

  always_ff @(posedge clk) begin
    if (rst) begin
      code <= '0;
    end else if (cmd.code_clear) begin
      code <= '0;
    end else if (cmd.code_acc) begin
      code <= (acc > {5'd0, hed_pkg::CODE_LIMIT}) ? hed_pkg::CODE_LIMIT : acc[16:0];
    end
  end

  // Candidate names still matching the held prefix.
  always_comb begin
    for (int k = 0; k < hed_pkg::NUM_NAMES; k++) begin
      mask_next[k] = mask[k] && (held_count < CW'(hed_pkg::NAME_LEN[k])) &&
                     (hed_pkg::NAME_TXT[k][{held_count[2:0], 3'b000} +: 8] == sym_byte);
    end
  end

  // Lookup of a complete name at the semicolon.
  always_comb begin
    name_bytes = {16'd0, hed_pkg::CH_QUEST};
    name_last  = 2'd0;
    for (int k = hed_pkg::NUM_NAMES - 1; k >= 0; k--) begin
      if (mask[k] && held_count == CW'(hed_pkg::NAME_LEN[k])) begin
        name_bytes = hed_pkg::NAME_OUT[k];
        name_last  = hed_pkg::NAME_LAST[k];
      end
    end
  end

  // UTF-8 form of the numeric code, or '?' for a saturated code.
  always_comb begin
    if (code < 17'h80) begin
      code_bytes = {16'd0, code[7:0]};
      code_last  = 2'd0;
    end else if (code < 17'h800) begin
      code_bytes = {8'd0, 2'b10, code[5:0], 3'b110, code[10:6]};
      code_last  = 2'd1;
    end else if (code < hed_pkg::CODE_LIMIT) begin
      code_bytes = {2'b10, code[5:0], 2'b10, code[11:6], 4'b1110, code[15:12]};
      code_last  = 2'd2;
    end else begin
      code_bytes = {16'd0, hed_pkg::CH_QUEST};
      code_last  = 2'd0;
    end
  end

  // Held count, name candidates and replay pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      rp_idx     <= '0;
      rp_len     <= '0;
      rp_active  <= 1'b0;
      mask       <= '1;
    end else begin
      if (cmd.name_init) begin
        held_count <= '0;
        mask       <= '1;
      end else if (cmd.hold) begin
        held_count <= held_count + CW'(1);
        mask       <= mask_next;
      end else if (cmd.rp_start) begin
        held_count <= '0;
      end
      if (cmd.rp_start) begin
        rp_idx    <= '0;
        rp_len    <= held_count;
        rp_active <= (held_count != '0);
      end else if (cmd.rp_step) begin
        rp_idx    <= rp_idx + CW'(1);
        rp_active <= (rp_idx + CW'(1) != rp_len);
      end
    end
  end

  // Result bundle of the current decode step.
  always_ff @(posedge clk) begin
    if (cmd.bun_sel != hed_pkg::BUN_NONE) begin
      bun_has  <= 1'b1;
      bun_done <= 1'b0;
      bun_ovf  <= 1'b0;
      bun_b1   <= hed_pkg::CH_HASH;
      bun_b2   <= 8'd0;
      bun_lastidx <= 2'd0;
      case (cmd.bun_sel)
        hed_pkg::BUN_BYTE: bun_b0 <= sym_byte;
        hed_pkg::BUN_DONE: begin
          bun_b0   <= 8'd0;
          bun_has  <= 1'b0;
          bun_done <= 1'b1;
        end
        hed_pkg::BUN_AMP: bun_b0 <= hed_pkg::CH_AMP;
        hed_pkg::BUN_AMP_OVF: begin
          bun_b0  <= hed_pkg::CH_AMP;
          bun_ovf <= 1'b1;
        end
        hed_pkg::BUN_AMP_HASH: begin
          bun_b0      <= hed_pkg::CH_AMP;
          bun_lastidx <= 2'd1;
        end
        hed_pkg::BUN_CODE: begin
          {bun_b2, bun_b1, bun_b0} <= code_bytes;
          bun_lastidx              <= code_last;
        end
        default: begin
          {bun_b2, bun_b1, bun_b0} <= name_bytes;
          bun_lastidx              <= name_last;
        end
      endcase
    end
  end

  // Position inside the bundle being sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      eidx <= '0;
    end else if (cmd.bun_sel != hed_pkg::BUN_NONE) begin
      eidx <= '0;
    end else if (cmd.emit) begin
      eidx <= eidx + 2'd1;
    end
  end

  always_comb begin
    case (eidx)
      2'd0:    emit_byte = bun_b0;
      2'd1:    emit_byte = bun_b1;
      default: emit_byte = bun_b2;
    endcase
  end

  // Output register; the decoder keeps working while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (text_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      text_out.out_byte        <= emit_byte;
      text_out.has_byte        <= bun_has;
      text_out.string_done     <= bun_done;
      text_out.entity_overflow <= bun_ovf;
    end
  end

  assign text_out.valid = out_valid;

  // Status toward the controller.
  always_comb begin
    sts.sym_end   = sym_end;
    sts.sym_term  = !sym_end && sym_byte == terminator;
    sts.sym_amp   = !sym_end && sym_byte == hed_pkg::CH_AMP;
    sts.sym_semi  = !sym_end && sym_byte == hed_pkg::CH_SEMI;
    sts.sym_hash  = !sym_end && sym_byte == hed_pkg::CH_HASH;
    sts.sym_x     = !sym_end && (sym_byte == hed_pkg::CH_LOW_X ||
                                 sym_byte == hed_pkg::CH_UP_X);
    sts.sym_brk   = sym_end || sym_byte == hed_pkg::CH_SPACE || sym_byte == hed_pkg::CH_LT;
    sts.dig_dec   = dig_dec;
    sts.dig_hex   = dig_hex;
    sts.held_zero = held_count == '0;
    sts.held_full = held_count == CW'(MAX_ENTITY);
    sts.rp_active = rp_active;
    sts.rp_last   = rp_idx + CW'(1) == rp_len;
    sts.bun_last  = eidx == bun_lastidx;
    sts.slot_free = !out_valid || text_out.ready;
  end

endmodule

[rtl/hed_ctrl.sv]
// Controller of the HTML entity decoder: sequencing and decode-mode state machine.
module hed_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  hed_pkg::sts_t sts,
  output hed_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_PROC  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [2:0] MD_PLAIN = 3'd0;
  localparam logic [2:0] MD_NAME  = 3'd1;
  localparam logic [2:0] MD_HASH  = 3'd2;
  localparam logic [2:0] MD_DEC   = 3'd3;
  localparam logic [2:0] MD_HEX   = 3'd4;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] resume;
  logic [1:0] resume_next;
  logic [2:0] mode;
  logic [2:0] mode_next;
  logic       do_consume;
  logic       do_replay;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      resume <= ST_IDLE;
      mode   <= MD_PLAIN;
    end else begin
      state  <= state_next;
      resume <= resume_next;
      mode   <= mode_next;
    end
  end

  assign in_ready = state == ST_IDLE;

  // Decode one symbol per step and choose where to go next.
  always_comb begin
    cmd         = '0;
    cmd.bun_sel = hed_pkg::BUN_NONE;
    state_next  = state;
    resume_next = resume;
    mode_next   = mode;
    do_consume  = 1'b0;
    do_replay   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_PROC;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_PROC;
      end
      ST_PROC: begin
        case (mode)
          MD_NAME: begin
            if (sts.sym_brk) begin
              cmd.bun_sel = hed_pkg::BUN_AMP;
              mode_next   = MD_PLAIN;
              do_replay   = 1'b1;
            end else if (sts.sym_semi) begin
              cmd.bun_sel   = hed_pkg::BUN_NAME;
              cmd.name_init = 1'b1;
              mode_next     = MD_PLAIN;
              do_consume    = 1'b1;
            end else if (sts.held_zero && sts.sym_hash) begin
              cmd.code_clear = 1'b1;
              mode_next      = MD_HASH;
              do_consume     = 1'b1;
            end else if (!sts.held_full) begin
              cmd.hold   = 1'b1;
              do_consume = 1'b1;
            end else begin
              cmd.bun_sel = hed_pkg::BUN_AMP_OVF;
              mode_next   = MD_PLAIN;
              do_replay   = 1'b1;
            end
          end
          MD_HASH: begin
            if (sts.sym_x) begin
              mode_next  = MD_HEX;
              do_consume = 1'b1;
            end else begin
              mode_next = MD_DEC;
            end
          end
          MD_DEC, MD_HEX: begin
            if (sts.sym_semi) begin
              cmd.bun_sel    = hed_pkg::BUN_CODE;
              cmd.code_clear = 1'b1;
              mode_next      = MD_PLAIN;
              do_consume     = 1'b1;
            end else if ((mode == MD_HEX) ? sts.dig_hex : sts.dig_dec) begin
              cmd.code_acc = 1'b1;
              cmd.code_hex = mode == MD_HEX;
              do_consume   = 1'b1;
            end else begin
              cmd.bun_sel    = hed_pkg::BUN_AMP_HASH;
              cmd.code_clear = 1'b1;
              mode_next      = MD_PLAIN;
            end
          end
          default: begin
            mode_next  = MD_PLAIN;
            do_consume = 1'b1;
            if (sts.sym_end || sts.sym_term) begin
              cmd.bun_sel = hed_pkg::BUN_DONE;
            end else if (sts.sym_amp) begin
              cmd.name_init = 1'b1;
              mode_next     = MD_NAME;
            end else begin
              cmd.bun_sel = hed_pkg::BUN_BYTE;
            end
          end
        endcase
        // Next symbol: following replay byte, the item, or a new item.
        if (do_replay) begin
          cmd.rp_start = 1'b1;
          resume_next  = sts.held_zero ? ST_PROC : ST_FETCH;
        end else if (do_consume) begin
          if (sts.rp_active) begin
            cmd.rp_step = 1'b1;
            resume_next = sts.rp_last ? ST_PROC : ST_FETCH;
          end else begin
            resume_next = ST_IDLE;
          end
        end else begin
          resume_next = ST_PROC;
        end
        state_next = (cmd.bun_sel != hed_pkg::BUN_NONE) ? ST_EMIT : resume_next;
      end
      default: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.bun_last) begin
            state_next = resume;
          end
        end
      end
    endcase
  end

  // A result is only loaded into a free output slot.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.slot_free)
    else $error("result emitted into an occupied output slot");

  // Held bytes are only read back during a replay.
  a_fetch_replay: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |-> sts.rp_active)
    else $error("held byte fetched outside a replay");

  // A new item is never taken while a replay is still pending.
  a_load_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |-> !sts.rp_active)
    else $error("item accepted during a replay");

  // A replay of held bytes reads the first one before decoding it.
  a_replay_fetch: assert property (@(posedge clk) disable iff (rst)
    (cmd.rp_start && !sts.held_zero) |=> (state == ST_FETCH || state == ST_EMIT))
    else $error("replay did not start with a fetch");

endmodule

[rtl/html_entity_decoder.sv]
// Top level of the HTML entity decoder: controller, datapath and ports.
//
// text_in carries one text byte (or an end marker) per request; text_out carries
// decoded results: a byte, or a string-done marker, with an overflow flag.
// cfg_we/cfg_data write the terminator byte (reset value '<'); write it only
// while the decoder is idle.
// Each input request is loaded and then decoded; every result that it causes
// takes one emit step of its own, after the decode step.
// A failed or overflowing name additionally replays its held bytes from the
// name memory, each held byte read and then decoded, up to MAX_ENTITY.
// The output has a register of its own: a result waits there while the decoder
// carries on, and the decoder stalls only when a second result is ready.
// Synchronous reset returns to plain text with nothing held and the terminator
// at '<'; the name memory needs no clearing.
module html_entity_decoder #(
  parameter int MAX_ENTITY = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  hed_in_if.sink     text_in,
  hed_out_if.source  text_out
);

  hed_pkg::cmd_t cmd;
  hed_pkg::sts_t sts;
  logic          in_ready;

  assign text_in.ready = in_ready;

  hed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text_in.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hed_dp #(
    .MAX_ENTITY (MAX_ENTITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_byte     (text_in.in_byte),
    .end_of_text (text_in.end_of_text),
    .cmd         (cmd),
    .sts         (sts),
    .text_out    (text_out)
  );

endmodule
